### design/rnts_pkg.sv
// Shared types, constants and table helpers for the radix number to symbols unit.
package rnts_pkg;

	localparam int MAX_BASE   = 16;
	localparam int MAX_DIGITS = 64;
	localparam int VAL_W      = 64;
	localparam int DIG_W      = 4;
	localparam int RADIX_W    = 5;
	localparam int CNT_W      = 7;
	localparam int ADDR_W     = 6;
	localparam int SYM_W      = 8;
	localparam int TBL_W      = SYM_W * MAX_BASE;

	localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

	localparam logic [RADIX_W-1:0] BASE_LENGTH_RST  = 5'd10;
	localparam logic [VAL_W-1:0]   SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [VAL_W-1:0]   SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

	typedef enum logic [1:0] {
		REG_BASE_LENGTH  = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [RADIX_W-1:0] base_length;
		logic [TBL_W-1:0]   symbols;     // {symbols_high, symbols_low}
	} cfg_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             ok;
	} job_t;

	function automatic logic [SYM_W-1:0] symbol_at(logic [TBL_W-1:0] tbl,
		logic [DIG_W-1:0] d);
		return tbl[{d, 3'b000} +: SYM_W];
	endfunction

	// Two to 16 symbols, none a sign character, no repeats.
	function automatic logic table_valid(cfg_t c);
		logic ok;
		logic [SYM_W-1:0] s;
		ok = (c.base_length >= 5'd2) && (c.base_length <= RADIX_W'(MAX_BASE));
		for (int a = 0; a < 16; a++) begin
			s = symbol_at(c.symbols, DIG_W'(a));
			if (RADIX_W'(a) < c.base_length) begin
				if (s == SIGN_PLUS || s == SIGN_MINUS)
					ok = 1'b0;
				for (int b = a + 1; b < 16; b++) begin
					if (RADIX_W'(b) < c.base_length &&
							symbol_at(c.symbols, DIG_W'(b)) == s)
						ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

endpackage

### design/rnts_if.sv
// Valid/ready channel interfaces: value input, symbol output, register writes.
interface rnts_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface rnts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       is_last;
	logic       base_ok;
	logic [6:0] digit_count;
	modport source (output valid, output symbol, output is_last, output base_ok,
		output digit_count, input ready);
	modport sink (input valid, input symbol, input is_last, input base_ok,
		input digit_count, output ready);
endinterface

interface rnts_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/radix_number_to_symbols_unit.sv
// Top level of the radix number to symbols unit.
//
// din takes a 64-bit unsigned value per item; dout gives one item per digit,
// most significant first, each a byte of the configured symbol table. The
// last item of a value has is_last set and carries the digit count. If the
// table is invalid (fewer than two or more than 16 symbols, a '+' or '-', or
// a repeated symbol) a value gives one item: symbol 0, base_ok 0, count 0.
// cfg writes base_length (0), symbols_low (1), symbols_high (2); always ready.
// Write it only while the unit is idle.
// Operation: each digit comes from the one shift-subtract divider (one quotient
// bit per cycle), and each emitted digit passes through a stack read (S_RD)
// and an output load (S_EMIT). Values are converted one at a time. Values
// wait in a QUEUE_DEPTH-entry queue, so din accepts up to that many values
// while the engine works or dout is stalled, then drops ready; a stalled dout
// holds its item and the engine waits. Reset restores the default table
// (radix 10, "0".."9") and empties the queue and the output register.
module radix_number_to_symbols_unit import rnts_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	rnts_in_if.sink     din,
	rnts_out_if.source  dout,
	rnts_cfg_if.sink    cfg
);

	cfg_t cfg_cur;
	job_t push_job;
	job_t pop_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	rnts_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.din     (din),
		.q_full  (q_full),
		.push    (push),
		.push_job(push_job),
		.cfg_cur (cfg_cur)
	);

	rnts_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	rnts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_cur(cfg_cur),
		.job    (pop_job),
		.q_empty(q_empty),
		.pop    (pop),
		.dout   (dout)
	);

`ifndef SYNTHESIS
	a_bad_table_item: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.base_ok |->
			dout.is_last && dout.symbol == 8'd0 && dout.digit_count == 7'd0)
		else $error("invalid-table item malformed");

	a_count_on_last_only: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.is_last |-> dout.base_ok && dout.digit_count == 7'd0)
		else $error("digit count on non-final item");

	a_last_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.is_last && dout.base_ok |->
			dout.digit_count != 7'd0 && dout.digit_count <= 7'd64)
		else $error("final digit count out of range");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty && !push |=> !pop || !q_empty)
		else $error("queue popped while empty");
`endif

endmodule

### design/rnts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rnts_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/rnts_front.sv
// Front end: configuration registers, table check and value intake.
module rnts_front import rnts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rnts_cfg_if.sink   cfg,
	rnts_in_if.sink    din,
	input  logic       q_full,
	output logic       push,
	output job_t       push_job,
	output cfg_t       cfg_cur
);

	logic [RADIX_W-1:0] base_length_q;
	logic [VAL_W-1:0]   symbols_low_q;
	logic [VAL_W-1:0]   symbols_high_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q  <= BASE_LENGTH_RST;
			symbols_low_q  <= SYMBOLS_LOW_RST;
			symbols_high_q <= SYMBOLS_HIGH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BASE_LENGTH:  base_length_q  <= cfg.data[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  symbols_low_q  <= cfg.data;
				REG_SYMBOLS_HIGH: symbols_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_cur.base_length = base_length_q;
	assign cfg_cur.symbols     = {symbols_high_q, symbols_low_q};

	assign din.ready      = !q_full;
	assign push           = din.valid && !q_full;
	assign push_job.value = din.value;
	assign push_job.ok    = table_valid(cfg_cur);

endmodule

### design/rnts_fifo.sv
// Short job queue between the front end and the digit engine.
module rnts_fifo import rnts_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	job_t               slot_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full    = (count_q == CNT_W_Q'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### design/rnts_back.sv
// Digit engine: shift-subtract division per digit, digit stack, MSB-first emit.
module rnts_back import rnts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg_cur,
	input  job_t        job,
	input  logic        q_empty,
	output logic        pop,
	rnts_out_if.source  dout
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_RD   = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [VAL_W-1:0]   quo_q;
	logic [DIG_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  bit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   k_q;
	logic               bad_q;

	logic               out_valid_q;
	logic [SYM_W-1:0]   sym_q;
	logic               last_q;
	logic               ok_q;
	logic [CNT_W-1:0]   count_out_q;

	logic [RADIX_W-1:0] trial;
	logic               ge;
	logic [DIG_W-1:0]   rem_n;
	logic [VAL_W-1:0]   quo_n;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [DIG_W-1:0]   wdata;
	logic [ADDR_W-1:0]  raddr;
	logic [DIG_W-1:0]   rdata;
	logic               slot_free;
	logic               emit_last;
	logic               load;

	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign ge    = (trial >= cfg_cur.base_length);
	assign rem_n = ge ? DIG_W'(trial - cfg_cur.base_length) : DIG_W'(trial);
	assign quo_n = {quo_q[VAL_W-2:0], ge};

	assign pop = (state_q == S_IDLE) && !q_empty;

	// Zero input with a valid table writes digit 0 directly; otherwise each finished division writes.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[ADDR_W-1:0];
		wdata = rem_n;
		if (pop && job.ok && job.value == '0) begin
			we    = 1'b1;
			waddr = '0;
			wdata = '0;
		end else if (state_q == S_DIV && bit_q == ADDR_W'(VAL_W - 1)) begin
			we = 1'b1;
		end
	end

	assign raddr = ADDR_W'(cnt_q - CNT_W'(1) - k_q);

	rnts_ram #(
		.WIDTH(DIG_W),
		.DEPTH(MAX_DIGITS)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign slot_free = !out_valid_q || dout.ready;
	assign emit_last = bad_q || (k_q + CNT_W'(1) == cnt_q);
	assign load      = (state_q == S_EMIT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			quo_q   <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						k_q   <= '0;
						bad_q <= !job.ok;
						quo_q <= job.value;
						rem_q <= '0;
						bit_q <= '0;
						if (!job.ok) begin
							cnt_q   <= '0;
							state_q <= S_EMIT;
						end else if (job.value == '0) begin
							cnt_q   <= CNT_W'(1);
							state_q <= S_RD;
						end else begin
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					quo_q <= quo_n;
					bit_q <= bit_q + 1'b1;
					if (bit_q == ADDR_W'(VAL_W - 1)) begin
						rem_q <= '0;
						cnt_q <= cnt_q + 1'b1;
						if (quo_n == '0 || cnt_q == CNT_W'(MAX_DIGITS - 1))
							state_q <= S_RD;
					end else begin
						rem_q <= rem_n;
					end
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						k_q     <= k_q + 1'b1;
						state_q <= emit_last ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= load || (out_valid_q && !dout.ready);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sym_q       <= bad_q ? '0 : symbol_at(cfg_cur.symbols, rdata);
			last_q      <= emit_last;
			ok_q        <= !bad_q;
			count_out_q <= emit_last ? cnt_q : '0;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.symbol      = sym_q;
	assign dout.is_last     = last_q;
	assign dout.base_ok     = ok_q;
	assign dout.digit_count = count_out_q;

endmodule

### tb/radix_number_to_symbols_unit_tb.sv
// Testbench for radix_number_to_symbols_unit: directed and random values, self-checking.
`timescale 1ns / 100ps

module radix_number_to_symbols_unit_tb;
	import rnts_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] DEC_LOW = SYMBOLS_LOW_RST;
	localparam logic [63:0] DEC_HIGH = SYMBOLS_HIGH_RST;
	localparam logic [63:0] HEX_LOW = 64'h3736_3534_3332_3130;
	localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
		logic       base_ok;
		logic [6:0] digit_count;
	} symbol_item_t;

	logic clk;
	logic arst_n;

	rnts_in_if  value_if();
	rnts_out_if symbol_if();
	rnts_cfg_if reg_if();

	radix_number_to_symbols_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (value_if),
		.dout   (symbol_if),
		.cfg    (reg_if)
	);

	// local copy of the register file
	logic [4:0]  model_base_len = BASE_LENGTH_RST;
	logic [63:0] model_sym_low  = SYMBOLS_LOW_RST;
	logic [63:0] model_sym_high = SYMBOLS_HIGH_RST;

	symbol_item_t pending_symbols[$];
	int mismatch_count = 0;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_sink = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < 40)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic logic [7:0] model_symbol(int d);
		logic [127:0] tbl;
		tbl = {model_sym_high, model_sym_low};
		return tbl[d*8 +: 8];
	endfunction

	function automatic bit model_table_ok();
		int n;
		logic [7:0] s;
		n = int'(model_base_len);
		if (n < 2 || n > MAX_BASE)
			return 1'b0;
		for (int a = 0; a < n; a++) begin
			s = model_symbol(a);
			if (s == SIGN_PLUS || s == SIGN_MINUS)
				return 1'b0;
			for (int b = a + 1; b < n; b++)
				if (model_symbol(b) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queue the symbols that one accepted value must produce.
	function automatic void predict_symbols(logic [63:0] v);
		logic [3:0] digits [MAX_DIGITS];
		logic [63:0] rest;
		logic [63:0] radix;
		int n;
		symbol_item_t it;
		if (!model_table_ok()) begin
			it.symbol = 8'h00;
			it.is_last = 1'b1;
			it.base_ok = 1'b0;
			it.digit_count = 7'd0;
			pending_symbols.push_back(it);
			return;
		end
		radix = 64'(model_base_len);
		rest = v;
		n = 0;
		if (rest == 64'd0) begin
			digits[0] = 4'd0;
			n = 1;
		end
		while (rest != 64'd0 && n < MAX_DIGITS) begin
			digits[n] = 4'(rest % radix);
			rest = rest / radix;
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			it.symbol = model_symbol(int'(digits[k]));
			it.is_last = (k == 0);
			it.base_ok = 1'b1;
			it.digit_count = (k == 0) ? 7'(n) : 7'd0;
			pending_symbols.push_back(it);
		end
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [63:0] data);
		reg_if.valid <= 1'b1;
		reg_if.index <= idx;
		reg_if.data <= data;
		@(posedge clk);
		while (!reg_if.ready)
			@(posedge clk);
		reg_if.valid <= 1'b0;
		case (idx)
			REG_BASE_LENGTH:  model_base_len = data[4:0];
			REG_SYMBOLS_LOW:  model_sym_low = data;
			REG_SYMBOLS_HIGH: model_sym_high = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_table(logic [4:0] base, logic [63:0] low, logic [63:0] high);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		// upper bits of the length write carry noise; only the low five count
		write_reg(REG_BASE_LENGTH, {noise[63:5], base});
		write_reg(REG_SYMBOLS_LOW, low);
		write_reg(REG_SYMBOLS_HIGH, high);
	endtask

	// Offer one value; valid stays high on return so back-to-back items stream.
	task automatic send_value(logic [63:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			value_if.valid <= 1'b0;
			@(posedge clk);
		end
		value_if.valid <= 1'b1;
		value_if.value <= v;
		@(posedge clk);
		while (!value_if.ready)
			@(posedge clk);
		predict_symbols(v);
	endtask

	task automatic wait_idle();
		value_if.valid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Checker and sink-side flow control.
	always @(posedge clk) begin
		symbol_item_t got;
		symbol_item_t want;
		if (arst_n) begin
			if (symbol_if.valid && symbol_if.ready) begin
				got.symbol = symbol_if.symbol;
				got.is_last = symbol_if.is_last;
				got.base_ok = symbol_if.base_ok;
				got.digit_count = symbol_if.digit_count;
				if (pending_symbols.size() == 0) begin
					report_mismatch($sformatf("unexpected item sym %h last %b ok %b cnt %0d",
						got.symbol, got.is_last, got.base_ok, got.digit_count));
				end else begin
					want = pending_symbols.pop_front();
					if (got !== want)
						report_mismatch($sformatf(
							"got sym %h last %b ok %b cnt %0d, want %h %b %b %0d",
							got.symbol, got.is_last, got.base_ok, got.digit_count,
							want.symbol, want.is_last, want.base_ok, want.digit_count));
				end
			end
		end
		symbol_if.ready <= arst_n && !hold_sink &&
			($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic logic [127:0] distinct_table(int radix);
		bit used [256];
		logic [127:0] tbl;
		int s;
		for (int i = 0; i < 16; i++) begin
			if (i < radix) begin
				do
					s = $urandom_range(0, 255);
				while (used[s] || s == SIGN_PLUS || s == SIGN_MINUS);
				used[s] = 1'b1;
				tbl[i*8 +: 8] = 8'(s);
			end else begin
				// unused slots may hold anything, signs and repeats included
				tbl[i*8 +: 8] = 8'($urandom);
			end
		end
		return tbl;
	endfunction

	function automatic logic [63:0] random_value(int radix);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return 64'($urandom_range(0, radix * radix * radix));
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	task automatic run_random_phase(int items);
		int sent;
		int radix;
		int burst;
		int pos;
		logic [127:0] tbl;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(0, 9))
				0: begin
					radix = $urandom_range(0, 31);
					tbl = {$urandom, $urandom, $urandom, $urandom};
				end
				1: begin
					// well-formed table spoiled by a sign or a repeat
					radix = $urandom_range(2, 16);
					tbl = distinct_table(radix);
					pos = $urandom_range(0, radix - 1);
					case ($urandom_range(0, 2))
						0: tbl[pos*8 +: 8] = SIGN_PLUS;
						1: tbl[pos*8 +: 8] = SIGN_MINUS;
						default: tbl[pos*8 +: 8] = tbl[((pos + 1) % radix)*8 +: 8];
					endcase
				end
				2: begin
					radix = 2;
					tbl = distinct_table(radix);
				end
				default: begin
					radix = $urandom_range(2, 16);
					tbl = distinct_table(radix);
				end
			endcase
			write_table(5'(radix), tbl[63:0], tbl[127:64]);
			burst = $urandom_range(4, 10);
			for (int i = 0; i < burst; i++)
				send_value(random_value(radix < 2 ? 2 : radix));
			sent += burst;
			wait_idle();
		end
	endtask

	task automatic test_default_table();
		send_value(64'd0);
		send_value(64'd9);
		send_value(64'd10);
		send_value(64'd1234567890);
		send_value(ALL_ONES);
		send_value(64'h8000_0000_0000_0000);
		wait_idle();
	endtask

	task automatic test_binary_extremes();
		write_table(5'd2, 64'h3130, 64'd0);
		send_value(ALL_ONES);
		send_value(64'd0);
		send_value(64'd1);
		send_value(64'h8000_0000_0000_0000);
		wait_idle();
		// a zero byte is an ordinary symbol
		write_table(5'd2, 64'hFF00, ALL_ONES);
		send_value(64'd5);
		wait_idle();
	endtask

	task automatic test_hex_full_table();
		write_table(5'd16, HEX_LOW, HEX_HIGH);
		send_value(ALL_ONES);
		send_value(64'd0);
		send_value(64'hFEDC_BA98_7654_3210);
		wait_idle();
	endtask

	task automatic test_invalid_tables();
		write_table(5'd0, HEX_LOW, HEX_HIGH);
		send_value(64'd7);
		wait_idle();
		write_table(5'd1, HEX_LOW, HEX_HIGH);
		send_value(64'd7);
		wait_idle();
		write_table(5'd17, HEX_LOW, HEX_HIGH);
		send_value(64'd7);
		wait_idle();
		write_table(5'd31, HEX_LOW, HEX_HIGH);
		send_value(ALL_ONES);
		wait_idle();
		write_table(5'd10, {DEC_LOW[63:8], SIGN_PLUS}, DEC_HIGH);
		send_value(64'd42);
		wait_idle();
		write_table(5'd16, HEX_LOW, {SIGN_MINUS, HEX_HIGH[55:0]});
		send_value(64'd42);
		wait_idle();
		write_table(5'd10, DEC_LOW, 64'h3538);
		send_value(64'd42);
		wait_idle();
		// two zero bytes inside the length repeat each other
		write_table(5'd3, 64'h0000_0000_0000_4100, 64'd0);
		send_value(64'd42);
		wait_idle();
		// a sign past the length does not matter
		write_table(5'd3, {32'd0, SIGN_PLUS, 24'h323130}, {8'd0, SIGN_MINUS, 48'd0});
		send_value(64'd5);
		wait_idle();
		// index 3 maps to no register; the table must stay as it is
		write_reg(REG_UNUSED, {8{SIGN_PLUS}});
		send_value(64'd25);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		write_table(5'd10, DEC_LOW, DEC_HIGH);
		fork
			begin
				hold_sink <= 1'b1;
				repeat (600) @(posedge clk);
				hold_sink <= 1'b0;
			end
			begin
				for (int i = 0; i < 10; i++)
					send_value(64'($urandom_range(0, 999)));
			end
		join
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		value_if.valid = 1'b0;
		value_if.value = 64'd0;
		reg_if.valid = 1'b0;
		reg_if.index = REG_BASE_LENGTH;
		reg_if.data = 64'd0;
		send_idle_pct = 22;
		recv_idle_pct = 75;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_table();
		test_binary_extremes();
		test_hex_full_table();
		test_invalid_tables();

		run_random_phase(32);
		send_idle_pct = 75;
		recv_idle_pct = 22;
		run_random_phase(32);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_backpressure();
		run_random_phase(32);

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
